// File: sv/document_handle_table_top_defines.svh
// Assertion helpers used by the top-level RTL
`ifndef DOCUMENT_HANDLE_TABLE_TOP_DEFINES_SVH
`define DOCUMENT_HANDLE_TABLE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define DHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property during reset as well
`define DHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/dht_pkg.sv
`timescale 1ns / 1ps
package dht_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic ins_write;  // write insert into store and slot stats
    logic scan_start; // init delete scan
    logic scan_step;  // advance delete scan one step: read an entry or skip a slot
    logic del_write;  // commit delete of current entry
    logic rd_issue;   // issue lookup read
    logic out_load;   // capture result
  } dht_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t act;
    logic    full;
    logic    doc_zero;
    logic    hit;
    logic    scan_done;
  } dht_sts_t;

endpackage

// File: sv/document_handle_table_top.sv
`timescale 1ns / 1ps
// Insert and no-op go from accept through DECODE to the result word; lookup adds LOOK.
// Delete of id 0 finishes in DECODE; any other id stays in SCAN until a hit or the end of
// the scan of the document store read port, one entry per cycle plus a step per skipped slot.
// One word at a time: a new word is not taken while one is in flight; the next word is taken
// as the result word leaves. Synchronous active-high reset clears control,
// counters and slot statistics; store entries past the last handle are never used.
`include "document_handle_table_top_defines.svh"
module document_handle_table_top #(
  parameter int CAPACITY  = 1024,
  parameter int SLOT_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], document[65:2], handle[75:66], zero pad [79:76]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_handle[9:0], found_document[73:10], delete_ok[74], handle_count[84:75],
  // deleted_count[94:85], compact_advised[95]
  output logic [95:0] m_axis_tdata
);
  dht_pkg::dht_cmd_t cmd;
  dht_pkg::dht_sts_t sts;
  logic [9:0]  new_handle;
  logic [63:0] found_document;
  logic        delete_ok;
  logic [9:0]  handle_count;
  logic [9:0]  deleted_count;
  logic        compact_advised;

  dht_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  dht_datapath #(.CAPACITY(CAPACITY), .SLOT_SIZE(SLOT_SIZE)) u_dp (
    .clk(clk), .rst(rst),
    .in_word(s_axis_tdata[75:0]),
    .cmd(cmd), .sts(sts),
    .new_handle(new_handle), .found_document(found_document),
    .delete_ok(delete_ok), .handle_count(handle_count),
    .deleted_count(deleted_count), .compact_advised(compact_advised)
  );

  assign m_axis_tdata = {compact_advised, deleted_count, handle_count, delete_ok,
                         found_document, new_handle};

  `DHT_ASSERT(a_ins_del_excl, !(cmd.ins_write && cmd.del_write), "insert and delete together")
  `DHT_ASSERT(a_no_accept_busy, cmd.load |=> !s_axis_tready, "accepted word while busy")
  `DHT_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_axis_tvalid, "result valid after reset")
endmodule

// File: sv/dht_datapath.sv
`timescale 1ns / 1ps
module dht_datapath #(
  parameter int CAPACITY  = 1024,
  parameter int SLOT_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [75:0]       in_word,
  input  dht_pkg::dht_cmd_t cmd,
  output dht_pkg::dht_sts_t sts,
  output logic [9:0]        new_handle,
  output logic [63:0]       found_document,
  output logic              delete_ok,
  output logic [9:0]        handle_count,
  output logic [9:0]        deleted_count,
  output logic              compact_advised
);
  localparam int NUM_SLOTS = (CAPACITY + SLOT_SIZE - 1) / SLOT_SIZE;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int JW = $clog2(SLOT_SIZE + 1);
  localparam int CW = $clog2(SLOT_SIZE + 2);
  localparam int HW = $clog2(CAPACITY + 1);

  // entries at and above next_handle are never used, so the store needs no clear
  logic [63:0] doc_store [CAPACITY];
  logic [63:0] rd_data;
  logic [63:0] slot_min [NUM_SLOTS];
  logic [63:0] slot_max [NUM_SLOTS];
  logic [CW-1:0] slot_used [NUM_SLOTS];
  logic [CW-1:0] slot_del [NUM_SLOTS];

  logic [HW-1:0] next_handle;
  logic [HW-1:0] total_deleted;
  logic [1:0]  act;
  logic [63:0] doc;
  logic [9:0]  hnd;

  // scan pointers: slot, entry within slot, address of entry read last cycle
  logic [SW:0]   scan_slot;
  logic [JW-1:0] scan_j;
  logic [AW-1:0] cur_addr;
  logic          cur_valid;
  logic [AW-1:0] lk_addr;

  logic [SW-1:0] ss;
  logic          slot_ok;
  logic [CW-1:0] lim;
  logic [AW+SW:0] idx_wide;
  logic [AW-1:0] ins_addr;
  // slot and offset of next_handle, tracked alongside it
  logic [SW-1:0] ins_slot;
  logic [JW-1:0] ins_off;
  logic [SW-1:0] cur_slot;
  logic [AW-1:0] rd_addr;
  logic          lk_range;
  logic          lk_range_q;
  logic          lk_valid;

  assign ss  = scan_slot[SW-1:0];
  assign lim = (slot_used[ss] > CW'(SLOT_SIZE)) ? CW'(SLOT_SIZE) : slot_used[ss];
  assign slot_ok = !(slot_min[ss] > doc) && !(slot_max[ss] < doc)
                   && (slot_used[ss] > slot_del[ss]);
  assign idx_wide = (AW+SW+1)'(ss) * (AW+SW+1)'(SLOT_SIZE) + (AW+SW+1)'(scan_j);
  assign ins_addr = next_handle[AW-1:0];
  // scan slot holds while the entry read is checked
  assign cur_slot = ss;
  // only handles issued so far hold an id; handle 0 is reserved
  assign lk_range = (32'(hnd) < 32'(next_handle)) && (hnd != 10'd0);
  assign rd_addr  = cmd.rd_issue ? lk_addr : idx_wide[AW-1:0];
  assign lk_addr  = AW'(hnd);

  always_comb begin
    sts.act       = dht_pkg::action_t'(act);
    sts.full      = !(next_handle < HW'(CAPACITY));
    sts.doc_zero  = (doc == 64'd0);
    sts.hit       = cur_valid && (cur_addr != '0) && (rd_data == doc);
    sts.scan_done = !(scan_slot < (SW+1)'(NUM_SLOTS));
  end

  always_ff @(posedge clk) begin
    rd_data <= doc_store[rd_addr];
    if (cmd.ins_write) doc_store[ins_addr] <= doc;
    else if (cmd.del_write) doc_store[cur_addr] <= 64'd0;
    if (cmd.load) begin
      act <= in_word[1:0];
      doc <= in_word[65:2];
      hnd <= in_word[75:66];
    end
    if (cmd.out_load) begin
      new_handle      <= (act == dht_pkg::ACT_INSERT && !sts.full) ? 10'(next_handle) : 10'd0;
      found_document  <= lk_valid ? rd_data : 64'd0;
      delete_ok       <= (act == dht_pkg::ACT_DELETE) && (sts.doc_zero || sts.hit);
    end
  end

  always_ff @(posedge clk) begin
    lk_range_q <= lk_range;
  end
  assign lk_valid = lk_range_q && (act == dht_pkg::ACT_LOOKUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_handle   <= HW'(1);
      total_deleted <= '0;
      ins_slot      <= (SLOT_SIZE == 1) ? SW'(1) : '0;
      ins_off       <= (SLOT_SIZE == 1) ? '0 : JW'(1);
      cur_valid     <= 1'b0;
      scan_slot     <= '0;
      scan_j        <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_min[s] <= '1;
        slot_max[s] <= '0;
        slot_used[s] <= (s == 0) ? CW'(1) : '0;
        slot_del[s] <= '0;
      end
    end else begin
      if (cmd.ins_write) begin
        slot_used[ins_slot]     <= slot_used[ins_slot] + CW'(1);
        if (doc > slot_max[ins_slot]) slot_max[ins_slot] <= doc;
        if (doc < slot_min[ins_slot]) slot_min[ins_slot] <= doc;
        next_handle <= next_handle + HW'(1);
        if (ins_off == JW'(SLOT_SIZE - 1)) begin
          ins_off  <= '0;
          ins_slot <= ins_slot + SW'(1);
        end else begin
          ins_off <= ins_off + JW'(1);
        end
      end
      if (cmd.del_write) begin
        slot_del[cur_slot]      <= slot_del[cur_slot] + CW'(1);
        total_deleted           <= total_deleted + HW'(1);
      end
      if (cmd.scan_start) begin
        scan_slot <= '0;
        scan_j    <= '0;
        cur_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        // issue read of current entry, or move to the next slot once this one is exhausted or cannot hold the id
        cur_valid <= 1'b0;
        if (!sts.scan_done) begin
          if (slot_ok && (JW'(scan_j) < JW'(lim)) && (idx_wide < (AW+SW+1)'(CAPACITY))) begin
            cur_addr  <= idx_wide[AW-1:0];
            cur_valid <= 1'b1;
            scan_j    <= scan_j + JW'(1);
          end else begin
            scan_slot <= scan_slot + (SW+1)'(1);
            scan_j    <= '0;
          end
        end
      end else begin
        cur_valid <= 1'b0;
      end
    end
  end

  assign handle_count    = 10'(next_handle - HW'(1));
  assign deleted_count   = 10'(total_deleted);
  assign compact_advised = ({total_deleted, 2'b00} > {2'b00, next_handle});
endmodule

// File: sv/dht_ctrl.sv
`timescale 1ns / 1ps
module dht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd
);
  typedef enum logic [2:0] {IDLE, DECODE, SCAN, LOOK, DONE} state_t;
  state_t state;
  logic   scan_hit;

  assign in_ready = (state == IDLE) && (!out_valid || out_ready);
  assign scan_hit = sts.hit;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      DECODE: begin
        case (sts.act)
          dht_pkg::ACT_INSERT: begin
            cmd.ins_write = !sts.full;
            cmd.out_load  = 1'b1;
          end
          dht_pkg::ACT_DELETE: begin
            cmd.scan_start = !sts.doc_zero;
            cmd.out_load   = sts.doc_zero;
          end
          dht_pkg::ACT_LOOKUP: cmd.rd_issue = 1'b1;
          default: cmd.out_load = 1'b1;
        endcase
      end
      SCAN: begin
        if (scan_hit) begin
          cmd.del_write = 1'b1;
          cmd.out_load  = 1'b1;
        end else if (sts.scan_done) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      LOOK: cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (cmd.load) state <= DECODE;
        DECODE: begin
          if (cmd.out_load) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end else if (sts.act == dht_pkg::ACT_LOOKUP) begin
            state <= LOOK;
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (cmd.out_load) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        LOOK: begin
          out_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
